FILE: sv/bfha_pkg.sv
package bfha_pkg;
    localparam int HEAP_BYTES = 4096;
    localparam int TAG_WORDS  = HEAP_BYTES / 4;
    localparam int AW         = $clog2(TAG_WORDS);
    localparam int OW         = $clog2(HEAP_BYTES) + 1;
    localparam logic [OW-1:0] END_OFF   = OW'(HEAP_BYTES - 4);
    localparam logic [OW-1:0] FIRST_HDR = OW'(4);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_BADSIZE = 3'd2;
    localparam logic [2:0] ST_BADPTR  = 3'd3;
    localparam logic [2:0] ST_FREED   = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic          opcode;
        logic [12:0]   request_bytes;
        logic [11:0]   payload_offset;
    } req_t;

    typedef struct packed {
        logic [11:0] result_offset;
        logic [2:0]  status_code;
    } rsp_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [15:0]   wdata;
    } mem_cmd_t;
endpackage

FILE: sv/bfha_if.sv
interface bfha_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/bfha_tag_ram.sv
module bfha_tag_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  bfha_pkg::mem_cmd_t  cmd,
    output logic [15:0]         rdata,
    output logic                init_done
);
    import bfha_pkg::*;

    logic [15:0]   mem [TAG_WORDS];
    logic [AW:0]   clr_reg;
    logic [AW-1:0] ca;
    logic [15:0]   cv;

    assign init_done = clr_reg[AW];
    assign ca        = clr_reg[AW-1:0];

    // format word for the clearing pass
    always_comb
    begin
        cv = 16'd0;
        if ({1'b0, ca, 2'b00} == FIRST_HDR)
            cv = 16'(HEAP_BYTES - 8) | 16'd2;
        else if ({1'b0, ca, 2'b00} == OW'(HEAP_BYTES - 8))
            cv = 16'(HEAP_BYTES - 8);
        else if ({1'b0, ca, 2'b00} == END_OFF)
            cv = 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (!clr_reg[AW])
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!clr_reg[AW])
            mem[ca] <= cv;
        else if (cmd.we)
            mem[cmd.addr] <= cmd.wdata;
        rdata <= mem[cmd.addr];
    end
endmodule

FILE: sv/bfha_seq.sv
module bfha_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                init_done,
    input  logic                start,
    input  bfha_pkg::req_t      req,
    input  logic [15:0]         rdata,
    output bfha_pkg::mem_cmd_t  cmd,
    output logic                busy,
    output logic                done,
    output bfha_pkg::rsp_t      rsp
);
    import bfha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCAN, S_W1, S_W2, S_W3, S_NRD, S_NCHK,
        S_PRD, S_PCHK, S_DONE
    } state_t;

    state_t        state_reg;
    logic          op_reg;
    logic [OW-1:0] need_reg, off_reg, h_reg;
    logic [OW-1:0] best_reg, bsz_reg, bpb_reg;
    logic          found_reg;
    logic [OW-1:0] prev_reg, psz_reg;
    logic          pfree_reg;
    logic [OW-1:0] start_reg, tot_reg, pbit_reg;
    logic [OW-1:0] nx_reg;
    logic          rmw_reg;
    logic [OW-1:0] waddr_reg;
    logic [15:0]   wdat_reg;
    logic          we_reg;
    logic [OW-1:0] raddr_reg;
    logic [2:0]    st_reg;
    logic [11:0]   res_reg;

    logic [OW-1:0] sz, hoff;
    logic          sz_ok;

    // single shared add/compare: block end against the end mark
    assign sz    = OW'(rdata & 16'hFFF8);
    assign sz_ok = (sz != '0) && ((off_reg + sz) <= END_OFF);
    assign hoff  = OW'(req.payload_offset) - OW'(4);

    assign busy     = (state_reg != S_IDLE) || !init_done;
    assign done     = (state_reg == S_DONE);
    assign rsp      = '{result_offset: res_reg, status_code: st_reg};
    assign cmd.we   = we_reg;
    assign cmd.addr = we_reg ? waddr_reg[AW+1:2] : raddr_reg[AW+1:2];
    assign cmd.wdata = wdat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            we_reg    <= 1'b0;
            raddr_reg <= '0;
        end
        else
        begin
            we_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= req.opcode;
                        found_reg <= 1'b0;
                        pfree_reg <= 1'b0;
                        psz_reg   <= '0;
                        off_reg   <= FIRST_HDR;
                        raddr_reg <= FIRST_HDR;
                        res_reg   <= '0;
                        need_reg  <= OW'((req.request_bytes + 14'd11) & 14'h3FF8);
                        h_reg     <= hoff;
                        if (req.opcode == OP_ALLOC)
                        begin
                            if (req.request_bytes == '0 ||
                                OW'(req.request_bytes) > OW'(HEAP_BYTES))
                            begin
                                st_reg    <= ST_BADSIZE;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_SRD;
                        end
                        else if (req.payload_offset[2:0] != 3'd0 ||
                                 req.payload_offset < 12'd8 || hoff >= END_OFF)
                        begin
                            st_reg    <= ST_BADPTR;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_SRD;
                    end
                end
                S_SRD: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (off_reg >= END_OFF || !sz_ok)
                        begin
                            if (!found_reg)
                            begin
                                st_reg    <= ST_NOFIT;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                st_reg  <= ST_OK;
                                res_reg <= 12'(best_reg + OW'(4));
                                we_reg  <= 1'b1;
                                waddr_reg <= best_reg;
                                if (bsz_reg - need_reg >= OW'(8))
                                begin
                                    wdat_reg  <= 16'(need_reg | bpb_reg | OW'(1));
                                    nx_reg    <= best_reg + need_reg;
                                    tot_reg   <= bsz_reg - need_reg;
                                    rmw_reg   <= 1'b0;
                                end
                                else
                                begin
                                    wdat_reg  <= 16'(bsz_reg | bpb_reg | OW'(1));
                                    nx_reg    <= best_reg + bsz_reg;
                                    rmw_reg   <= 1'b1;
                                end
                                state_reg <= S_W1;
                            end
                        end
                        else
                        begin
                            if (!rdata[0] && sz >= need_reg &&
                                (!found_reg || sz < bsz_reg))
                            begin
                                found_reg <= 1'b1;
                                best_reg  <= off_reg;
                                bsz_reg   <= sz;
                                bpb_reg   <= OW'(rdata & 16'd2);
                            end
                            off_reg   <= off_reg + sz;
                            raddr_reg <= off_reg + sz;
                            state_reg <= S_SRD;
                        end
                    end
                    else
                    begin
                        if (off_reg >= END_OFF || off_reg > h_reg || !sz_ok)
                        begin
                            st_reg    <= ST_BADPTR;
                            state_reg <= S_DONE;
                        end
                        else if (off_reg == h_reg)
                        begin
                            if (!rdata[0])
                            begin
                                st_reg    <= ST_FREED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                st_reg    <= ST_OK;
                                if (pfree_reg)
                                begin
                                    start_reg <= prev_reg;
                                    tot_reg   <= sz + psz_reg;
                                end
                                else
                                begin
                                    start_reg <= h_reg;
                                    tot_reg   <= sz;
                                    pbit_reg  <= OW'(rdata & 16'd2);
                                end
                                nx_reg    <= h_reg + sz;
                                raddr_reg <= h_reg + sz;
                                state_reg <= S_NRD;
                            end
                        end
                        else
                        begin
                            prev_reg  <= off_reg;
                            psz_reg   <= sz;
                            pfree_reg <= !rdata[0];
                            pbit_reg  <= OW'(rdata & 16'd2);
                            off_reg   <= off_reg + sz;
                            raddr_reg <= off_reg + sz;
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_NRD:
                begin
                    off_reg   <= nx_reg;
                    state_reg <= S_NCHK;
                end
                S_NCHK:
                begin
                    // next neighbour free: absorb it
                    if (nx_reg < END_OFF && !rdata[0])
                        tot_reg <= tot_reg + (sz_ok ? sz : '0);
                    state_reg <= S_PRD;
                end
                S_PRD:
                begin
                    we_reg    <= 1'b1;
                    waddr_reg <= start_reg;
                    wdat_reg  <= 16'(tot_reg | pbit_reg);
                    nx_reg    <= start_reg + tot_reg;
                    raddr_reg <= start_reg + tot_reg;
                    rmw_reg   <= 1'b1;
                    state_reg <= S_W1;
                end
                S_W1:
                begin
                    if (op_reg == OP_ALLOC && !rmw_reg)
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= nx_reg;
                        wdat_reg  <= 16'(tot_reg | OW'(2));
                        state_reg <= S_W2;
                    end
                    else if (op_reg == OP_FREE)
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= start_reg + tot_reg - OW'(4);
                        wdat_reg  <= 16'(tot_reg);
                        state_reg <= S_W2;
                    end
                    else
                    begin
                        raddr_reg <= nx_reg;
                        state_reg <= S_W2;
                    end
                end
                S_W2:
                begin
                    if (op_reg == OP_ALLOC && !rmw_reg)
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= best_reg + bsz_reg - OW'(4);
                        wdat_reg  <= 16'(tot_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        raddr_reg <= nx_reg;
                        state_reg <= S_PCHK;
                    end
                end
                S_PCHK: state_reg <= S_W3;
                S_W3:
                begin
                    // previous-allocated bit of the following block
                    if (nx_reg < END_OFF)
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= nx_reg;
                        wdat_reg  <= (op_reg == OP_ALLOC) ? (rdata | 16'd2)
                                                          : (rdata & ~16'd2);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/best_fit_heap_allocator.sv
// best-fit heap allocator, one transfer in and one transfer out per request
// each request walks the block headers (the end mark too for an alloc)
// through the single tag ram read port, then updates the tags, then loads
// the output register; a new request is taken only once the previous one is
// done and its result has left the output register
// reset formats the tag ram in a clearing pass, during which no request is
// taken
module best_fit_heap_allocator (
    input  logic    clk,
    input  logic    rst_n,
    bfha_if.sink    req,
    bfha_if.source  rsp
);
    import bfha_pkg::*;

    mem_cmd_t    cmd;
    logic [15:0] rdata;
    logic        init_done, busy, done, start;
    rsp_t        rsp_w;
    logic        ov_reg;
    rsp_t        od_reg;
    req_t        rq;

    assign rq        = req_t'(req.data);
    // accept only when idle and the output slot is free
    assign req.ready = !busy && !ov_reg;
    assign start     = req.valid && req.ready;
    assign rsp.valid = ov_reg;
    assign rsp.data  = od_reg;

    bfha_tag_ram u_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rdata     (rdata),
        .init_done (init_done)
    );

    bfha_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .start     (start),
        .req       (rq),
        .rdata     (rdata),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp_w)
    );

    // output register holds the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
        begin
            ov_reg <= 1'b1;
            od_reg <= rsp_w;
        end
        else if (rsp.ready)
            ov_reg <= 1'b0;
    end
endmodule
